@@ rtl/uart_frame_transmitter_assert.svh @@
// Assertion macros for the serial transmitter.
`ifndef UART_FRAME_TRANSMITTER_ASSERT_SVH
`define UART_FRAME_TRANSMITTER_ASSERT_SVH

// Consequent holds in the same cycle as the antecedent.
`define UFT_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define UFT_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/uft_pkg.sv @@
package uft_pkg;

   localparam int MAX_DATA_BITS = 8;
   localparam int BYTE_W        = 8;
   localparam int CNT_W         = $clog2(MAX_DATA_BITS);
   localparam int NBITS_W       = 4;
   localparam int CPB_W         = 16;
   localparam int CSR_IDX_W     = 3;
   localparam int CSR_DATA_W    = 16;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_DATA_BITS      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_PARITY_MODE    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_STOP_BITS      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_CLOCKS_PER_BIT = 3'd3;

   // parity modes
   localparam logic [1:0] PARITY_NONE = 2'd0;
   localparam logic [1:0] PARITY_EVEN = 2'd1;
   localparam logic [1:0] PARITY_ODD  = 2'd2;

   // reset values
   localparam logic [NBITS_W-1:0] RESET_DATA_BITS = 4'd8;
   localparam logic [CPB_W-1:0]   RESET_CPB       = 16'd2186;

   // frame phases
   localparam logic [1:0] PH_START  = 2'd0;
   localparam logic [1:0] PH_DATA   = 2'd1;
   localparam logic [1:0] PH_PARITY = 2'd2;
   localparam logic [1:0] PH_STOP   = 2'd3;

   // effective (saturated) configuration
   typedef struct packed {
      logic [NBITS_W-1:0] nbits;
      logic               parity_en;
      logic               parity_odd;
      logic               stop_two;
      logic [CPB_W-1:0]   cpb;
   } uft_cfg_type;

   typedef struct packed {
      logic       load;
      logic       count;
      logic       emit;
      logic       advance;
      logic       last;
      logic [1:0] phase;
   } uft_cmd_type;

   typedef struct packed {
      logic baud_done;
      logic data_last;
      logic stop_last;
      logic out_taken;
   } uft_status_type;

endpackage

@@ rtl/uft_csr.sv @@
module uft_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [uft_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [uft_pkg::CSR_DATA_W-1:0] csr_data,
   output uft_pkg::uft_cfg_type           cfg
);
   import uft_pkg::*;

   uft_cfg_type cfg_ff, cfg_in;
   logic [NBITS_W-1:0] nbits_raw;
   logic [1:0]         mode_raw;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;
   assign nbits_raw = csr_data[NBITS_W-1:0];
   assign mode_raw  = csr_data[1:0];

   // decode write, saturate values as they are stored
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_DATA_BITS: begin
               if (nbits_raw == '0)
                  cfg_in.nbits = NBITS_W'(1);
               else if (nbits_raw > NBITS_W'(MAX_DATA_BITS))
                  cfg_in.nbits = NBITS_W'(MAX_DATA_BITS);
               else
                  cfg_in.nbits = nbits_raw;
            end
            REG_PARITY_MODE: begin
               cfg_in.parity_en  = (mode_raw == PARITY_EVEN) || (mode_raw == PARITY_ODD);
               cfg_in.parity_odd = (mode_raw == PARITY_ODD);
            end
            REG_STOP_BITS: begin
               // two and three both mean two stop bits
               cfg_in.stop_two = mode_raw[1];
            end
            REG_CLOCKS_PER_BIT: begin
               cfg_in.cpb = (csr_data == '0) ? CPB_W'(1) : csr_data;
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.nbits      <= RESET_DATA_BITS;
         cfg_ff.parity_en  <= 1'b0;
         cfg_ff.parity_odd <= 1'b0;
         cfg_ff.stop_two   <= 1'b0;
         cfg_ff.cpb        <= RESET_CPB;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

@@ rtl/uft_datapath.sv @@
module uft_datapath (
   input  logic                       clock,
   input  logic                       reset,
   input  uft_pkg::uft_cfg_type       cfg,
   input  uft_pkg::uft_cmd_type       cmd,
   output uft_pkg::uft_status_type    status,
   input  logic [uft_pkg::BYTE_W-1:0] data_byte,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic                       line_level,
   output logic                       frame_end
);
   import uft_pkg::*;

   logic [BYTE_W-1:0] shift_ff, shift_in;
   logic              parity_ff, parity_in;
   logic [CNT_W-1:0]  bit_cnt_ff, bit_cnt_in;
   logic              stop_cnt_ff, stop_cnt_in;
   logic [CPB_W-1:0]  baud_ff, baud_in;
   logic              valid_ff, valid_in;
   logic              level_ff, level_in;
   logic              last_ff, last_in;
   logic              level_sel;

   assign rsp_tvalid = valid_ff;
   assign line_level = level_ff;
   assign frame_end  = last_ff;

   assign status.baud_done = (baud_ff == CPB_W'(1));
   assign status.data_last = ({1'b0, bit_cnt_ff} == NBITS_W'(cfg.nbits - NBITS_W'(1)));
   assign status.stop_last = cfg.stop_two ? stop_cnt_ff : 1'b1;
   assign status.out_taken = valid_ff && rsp_tready;

   // pick the level of the current phase
   always_comb begin
      case (cmd.phase)
         PH_START:  level_sel = 1'b0;
         PH_DATA:   level_sel = shift_ff[0];
         PH_PARITY: level_sel = parity_ff ^ cfg.parity_odd;
         default:   level_sel = 1'b1;
      endcase
   end

   always_comb begin
      shift_in    = shift_ff;
      parity_in   = parity_ff;
      bit_cnt_in  = bit_cnt_ff;
      stop_cnt_in = stop_cnt_ff;
      baud_in     = baud_ff;
      valid_in    = valid_ff;
      level_in    = level_ff;
      last_in     = last_ff;

      // drop the result once taken
      if (valid_ff && rsp_tready)
         valid_in = 1'b0;

      if (cmd.load) begin
         shift_in    = data_byte;
         parity_in   = 1'b0;
         bit_cnt_in  = '0;
         stop_cnt_in = 1'b0;
         baud_in     = cfg.cpb;
      end

      // time the bit period
      if (cmd.count)
         baud_in = baud_ff - CPB_W'(1);

      if (cmd.emit) begin
         valid_in = 1'b1;
         level_in = level_sel;
         last_in  = cmd.last;
      end

      // step to the next bit of the frame
      if (cmd.advance) begin
         baud_in = cfg.cpb;
         if (cmd.phase == PH_DATA) begin
            shift_in   = {1'b0, shift_ff[BYTE_W-1:1]};
            parity_in  = parity_ff ^ shift_ff[0];
            bit_cnt_in = bit_cnt_ff + CNT_W'(1);
         end
         if (cmd.phase == PH_STOP)
            stop_cnt_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= 1'b0;
         bit_cnt_ff  <= '0;
         stop_cnt_ff <= 1'b0;
         baud_ff     <= RESET_CPB;
      end else begin
         valid_ff    <= valid_in;
         bit_cnt_ff  <= bit_cnt_in;
         stop_cnt_ff <= stop_cnt_in;
         baud_ff     <= baud_in;
      end
   end

   always_ff @(posedge clock) begin
      shift_ff  <= shift_in;
      parity_ff <= parity_in;
      level_ff  <= level_in;
      last_ff   <= last_in;
   end

endmodule

@@ rtl/uft_ctrl.sv @@
module uft_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  uft_pkg::uft_cfg_type    cfg,
   input  uft_pkg::uft_status_type status,
   output uft_pkg::uft_cmd_type    cmd,
   input  logic                    req_tvalid,
   output logic                    req_tready
);
   import uft_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_HOLD = 2'd1;
   localparam logic [1:0] ST_SEND = 2'd2;

   logic [1:0] state_ff, state_in;
   logic [1:0] phase_ff, phase_in;
   logic       frame_done;

   assign req_tready = (state_ff == ST_IDLE);
   assign frame_done = (phase_ff == PH_STOP) && status.stop_last;

   always_comb begin
      state_in    = state_ff;
      phase_in    = phase_ff;
      cmd         = '0;
      cmd.phase   = phase_ff;
      cmd.last    = frame_done;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               phase_in = PH_START;
               state_in = ST_HOLD;
            end
         end
         ST_HOLD: begin
            // hold the level for the bit period, then post it
            if (status.baud_done) begin
               cmd.emit = 1'b1;
               state_in = ST_SEND;
            end else begin
               cmd.count = 1'b1;
            end
         end
         ST_SEND: begin
            if (status.out_taken) begin
               if (frame_done) begin
                  state_in = ST_IDLE;
               end else begin
                  cmd.advance = 1'b1;
                  state_in    = ST_HOLD;
                  unique case (phase_ff)
                     PH_START: phase_in = PH_DATA;
                     PH_DATA: begin
                        if (!status.data_last)
                           phase_in = PH_DATA;
                        else if (cfg.parity_en)
                           phase_in = PH_PARITY;
                        else
                           phase_in = PH_STOP;
                     end
                     default: phase_in = PH_STOP;
                  endcase
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         phase_ff <= PH_START;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
      end
   end

endmodule

@@ rtl/uart_frame_transmitter.sv @@
// Serial frame transmitter.
// req channel: one byte per item in req_tdata; the low data_bits bits are sent.
// rsp channel: one item per bit period of the frame, in line order: the start
// bit, data bits least significant first, the optional parity bit, then one or
// two stop bits. rsp_tdata[0] is the line level, rsp_tlast marks the final stop.
// csr channel: register writes (0 data_bits, 1 parity_mode, 2 stop_bits,
// 3 clocks_per_bit); always ready, to be used only while no frame is in flight.
// The bit-period counter is loaded from clocks_per_bit when the byte is taken;
// each level is posted when that counter runs out, and then sits in the output
// register until it is taken. A frame has 3 to 12 levels, and the counter is
// loaded again for each level; a new byte can be taken in the cycle after the
// final stop bit leaves, and not while a frame is in flight.
// Reset: registers return to 8 data bits, no parity, one stop bit, RESET_CPB as
// clocks_per_bit, and the transmitter goes idle with req_tready high.
// A stalled receiver freezes the frame: the pending level holds in the output
// register and the next bit period does not start until it is taken.
module uart_frame_transmitter (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [7:0]                     req_tdata,  // [7:0] data_byte
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [7:0]                     rsp_tdata,  // [0] line_level, [7:1] zero
   output logic                           rsp_tlast,  // frame_end
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [uft_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [uft_pkg::CSR_DATA_W-1:0] csr_data
);
   import uft_pkg::*;

   uft_cfg_type    cfg;
   uft_cmd_type    cmd;
   uft_status_type status;
   logic           line_level;

   assign rsp_tdata = {7'd0, line_level};

   uft_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   uft_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .status     (status),
      .cmd        (cmd),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready)
   );

   uft_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .cmd        (cmd),
      .status     (status),
      .data_byte  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .line_level (line_level),
      .frame_end  (rsp_tlast)
   );

   `include "uart_frame_transmitter_assert.svh"

   // a new byte is never taken while a level is still pending
   `UFT_ASSERT_SAME(a_no_overlap, clock, reset, req_tvalid && req_tready, !rsp_tvalid, "byte taken with level pending")
   // the flagged level is a stop bit
   `UFT_ASSERT_SAME(a_last_is_stop, clock, reset, rsp_tvalid && rsp_tlast, rsp_tdata[0], "frame end on low level")
   // after the final stop bit leaves, the transmitter is idle
   `UFT_ASSERT_NEXT(a_idle_after_frame, clock, reset, rsp_tvalid && rsp_tready && rsp_tlast, req_tready, "not idle after frame")
   // no level is posted in the cycle after a byte is loaded
   `UFT_ASSERT_NEXT(a_gap_after_load, clock, reset, req_tvalid && req_tready, !rsp_tvalid, "level posted too early")

endmodule
